// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== hdl/ltl_pkg.sv =====
// ---------------------------------------------------------------------------
// Line lookup package
// Sizes, operation and action codes, and the types shared by the block.
// ---------------------------------------------------------------------------
package ltl_pkg;

    localparam int MAX_LINES = 256;
    localparam int IDX_W     = 8;
    localparam int CNT_W     = 9;
    localparam int TIME_W    = 32;
    localparam int OP_W      = 2;
    localparam int ACT_W     = 2;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_SEEK  = 2'd2;

    localparam logic [ACT_W-1:0] ACT_KEEP  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BLANK = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SHOW  = 2'd2;

    localparam logic [CNT_W-1:0]  HINT_NONE = '1;
    localparam logic [TIME_W-1:0] TIME_NONE = '1;
    localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(MAX_LINES);

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] query_time;
        logic              force_req;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [IDX_W-1:0]  first_line;
        logic [IDX_W-1:0]  last_line;
        logic [TIME_W-1:0] line_time;
    } res_t;

    localparam res_t RES_KEEP  = '{ACT_KEEP, '0, '0, '0};
    localparam res_t RES_BLANK = '{ACT_BLANK, '0, '0, '0};

endpackage

// ===== hdl/lyric_timeline_line_lookup.sv =====
// A load, seek or other item goes straight to the walker's result state; its result then passes
// into the output register. A query first reads the time table (one read port, registered read data)
// and passes through a show state when a line group is shown. No lines: keep, or blank if forced.
// The reads are the walk down and up from the remembered line and the group scan on each side.
// The block takes one item at a time; the next is taken once the result is in the output register.
// Reset: line count cleared, no remembered line, nothing shown; the table is undefined.
// ---------------------------------------------------------------------------
// Lyric timeline line lookup
// Keeps the line start time table and answers playback position queries.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lyric_timeline_line_lookup (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ltl_pkg::CNT_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ltl_pkg::OP_W-1:0]    op,
    input  logic [ltl_pkg::IDX_W-1:0]   entry_index,
    input  logic [ltl_pkg::TIME_W-1:0]  entry_time,
    input  logic [ltl_pkg::TIME_W-1:0]  query_time,
    input  logic                        force_req,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ltl_pkg::ACT_W-1:0]   action,
    output logic [ltl_pkg::IDX_W-1:0]   first_line,
    output logic [ltl_pkg::IDX_W-1:0]   last_line,
    output logic [ltl_pkg::TIME_W-1:0]  line_time
);

    import ltl_pkg::*;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg;
    logic              in_accept;
    logic              walk_idle;
    logic              res_valid;
    logic              res_take;
    res_t              res;
    cmd_t              cmd;
    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W-1:0] rd_data;
    logic              out_tail_zero;

    assign in_stall  = !walk_idle;
    assign in_accept = in_valid && !in_stall;
    assign cmd       = '{op, query_time, force_req};

    ltl_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_LINES)
    ) u_table (
        .clk     (clk),
        .wr_en   (in_accept && op == OP_LOAD),
        .wr_addr (entry_index),
        .wr_data (entry_time),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ltl_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_accept),
        .cmd        (cmd),
        .line_count (count_reg),
        .idle       (walk_idle),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .res_valid  (res_valid),
        .res        (res),
        .res_take   (res_take)
    );

    assign res_take       = res_valid && (!out_valid_reg || !out_stall);
    assign count_next     = cfg_we ? cfg_data : count_reg;
    assign out_valid_next = res_take || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign action     = out_reg.action;
    assign first_line = out_reg.first_line;
    assign last_line  = out_reg.last_line;
    assign line_time  = out_reg.line_time;

    assign out_tail_zero = (first_line == '0) && (last_line == '0) && (line_time == '0);

    `ASSERT_PROP(a_busy_after_accept, clk, rst_n, in_accept |=> in_stall)
    `ASSERT_NEVER(a_zero_unless_show, clk, rst_n, out_valid && action != ACT_SHOW && !out_tail_zero)
    `ASSERT_NEVER(a_group_order, clk, rst_n, out_valid && action == ACT_SHOW && first_line > last_line)

endmodule

// ===== hdl/ltl_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ltl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ltl_walk.sv =====
// ---------------------------------------------------------------------------
// Line lookup walker
// Sequencer that walks the time table from the remembered line, finds the
// line group for a position and keeps the remembered line and shown time.
// ---------------------------------------------------------------------------
module ltl_walk (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  ltl_pkg::cmd_t              cmd,
    input  logic [ltl_pkg::CNT_W-1:0]  line_count,
    output logic                       idle,
    output logic [ltl_pkg::IDX_W-1:0]  rd_addr,
    input  logic [ltl_pkg::TIME_W-1:0] rd_data,
    output logic                       res_valid,
    output ltl_pkg::res_t              res,
    input  logic                       res_take
);

    import ltl_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DN_RD  = 12'b0000_0000_0010,
        S_DN_CHK = 12'b0000_0000_0100,
        S_UP_RD  = 12'b0000_0000_1000,
        S_UP_CHK = 12'b0000_0001_0000,
        S_FIN    = 12'b0000_0010_0000,
        S_LO_RD  = 12'b0000_0100_0000,
        S_LO_CHK = 12'b0000_1000_0000,
        S_HI_RD  = 12'b0001_0000_0000,
        S_HI_CHK = 12'b0010_0000_0000,
        S_SHOW   = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   pos_reg, pos_next;
    logic                force_reg, force_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [IDX_W-1:0]    i_reg, i_next;
    logic [IDX_W-1:0]    lo_reg, lo_next;
    logic [TIME_W-1:0]   t_reg, t_next;
    logic [CNT_W-1:0]    hint_reg, hint_next;
    logic [TIME_W-1:0]   shown_reg, shown_next;
    res_t                res_reg, res_next;

    logic [CNT_W-1:0]    cnt_act;
    logic [CNT_W-1:0]    i_ext;
    logic [CNT_W-1:0]    i_inc;
    logic [CNT_W-1:0]    i_inc2;
    state_t              hi_state;

    assign cnt_act  = (line_count > COUNT_MAX) ? COUNT_MAX : line_count;
    assign i_ext    = {1'b0, i_reg};
    assign i_inc    = i_ext + CNT_W'(1);
    assign i_inc2   = i_ext + CNT_W'(2);
    assign hi_state = (i_inc < n_reg) ? S_HI_RD : S_SHOW;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        force_next = force_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        lo_next    = lo_reg;
        t_next     = t_reg;
        hint_next  = hint_reg;
        shown_next = shown_reg;
        res_next   = res_reg;
        rd_addr    = i_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pos_next   = cmd.query_time;
                    force_next = cmd.force_req;
                    n_next     = cnt_act;
                    res_next   = RES_KEEP;
                    state_next = S_OUT;
                    if (cmd.op == OP_LOAD || cmd.op == OP_SEEK)
                    begin
                        hint_next  = HINT_NONE;
                        shown_next = TIME_NONE;
                    end
                    else if (cmd.op == OP_QUERY)
                    begin
                        if (cnt_act == '0)
                        begin
                            res_next = cmd.force_req ? RES_BLANK : RES_KEEP;
                        end
                        else
                        begin
                            i_next     = (hint_reg < cnt_act) ? hint_reg[IDX_W-1:0] : '0;
                            state_next = S_DN_RD;
                        end
                    end
                end
            end
            S_DN_RD:
            begin
                rd_addr    = i_reg;
                state_next = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (i_reg != '0 && rd_data > pos_reg)
                begin
                    i_next     = i_reg - IDX_W'(1);
                    state_next = S_DN_RD;
                end
                else
                begin
                    t_next     = rd_data;
                    state_next = (i_inc < n_reg) ? S_UP_RD : S_FIN;
                end
            end
            S_UP_RD:
            begin
                rd_addr    = i_inc[IDX_W-1:0];
                state_next = S_UP_CHK;
            end
            S_UP_CHK:
            begin
                if (rd_data <= pos_reg)
                begin
                    i_next     = i_inc[IDX_W-1:0];
                    t_next     = rd_data;
                    state_next = (i_inc2 < n_reg) ? S_UP_RD : S_FIN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
                if (t_reg > pos_reg)
                begin
                    if (force_reg || shown_reg != TIME_NONE)
                    begin
                        hint_next  = HINT_NONE;
                        shown_next = TIME_NONE;
                        res_next   = RES_BLANK;
                    end
                    else
                    begin
                        res_next = RES_KEEP;
                    end
                end
                else
                begin
                    hint_next = i_ext;
                    if (!force_reg && t_reg == shown_reg)
                    begin
                        res_next = RES_KEEP;
                    end
                    else
                    begin
                        shown_next = t_reg;
                        lo_next    = i_reg;
                        state_next = (i_reg != '0) ? S_LO_RD : hi_state;
                    end
                end
            end
            S_LO_RD:
            begin
                rd_addr    = lo_reg - IDX_W'(1);
                state_next = S_LO_CHK;
            end
            S_LO_CHK:
            begin
                if (rd_data == t_reg)
                begin
                    lo_next    = lo_reg - IDX_W'(1);
                    state_next = (lo_reg > IDX_W'(1)) ? S_LO_RD : hi_state;
                end
                else
                begin
                    state_next = hi_state;
                end
            end
            S_HI_RD:
            begin
                rd_addr    = i_inc[IDX_W-1:0];
                state_next = S_HI_CHK;
            end
            S_HI_CHK:
            begin
                if (rd_data == t_reg)
                begin
                    i_next     = i_inc[IDX_W-1:0];
                    state_next = (i_inc2 < n_reg) ? S_HI_RD : S_SHOW;
                end
                else
                begin
                    state_next = S_SHOW;
                end
            end
            S_SHOW:
            begin
                res_next   = '{ACT_SHOW, lo_reg, i_reg, t_reg};
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hint_reg  <= HINT_NONE;
            shown_reg <= TIME_NONE;
        end
        else
        begin
            state_reg <= state_next;
            hint_reg  <= hint_next;
            shown_reg <= shown_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        force_reg <= force_next;
        n_reg     <= n_next;
        i_reg     <= i_next;
        lo_reg    <= lo_next;
        t_reg     <= t_next;
        res_reg   <= res_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;

endmodule

// ===== test/lyric_timeline_line_lookup_checker.sv =====
// ---------------------------------------------------------------------------
// Line lookup checker
// Watches the configuration port and both transfer channels of the line
// lookup block, keeps its own copy of the time table, remembered line and
// shown time, predicts the answer to every accepted item and compares each
// result transfer field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module lyric_timeline_line_lookup_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ltl_pkg::CNT_W-1:0]   cfg_data,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [ltl_pkg::OP_W-1:0]    op,
    input  logic [ltl_pkg::IDX_W-1:0]   entry_index,
    input  logic [ltl_pkg::TIME_W-1:0]  entry_time,
    input  logic [ltl_pkg::TIME_W-1:0]  query_time,
    input  logic                        force_req,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [ltl_pkg::ACT_W-1:0]   action,
    input  logic [ltl_pkg::IDX_W-1:0]   first_line,
    input  logic [ltl_pkg::IDX_W-1:0]   last_line,
    input  logic [ltl_pkg::TIME_W-1:0]  line_time,
    output int                          answers_outstanding,
    output int                          mismatches
);
    timeunit 1ns;
    timeprecision 1ps;
    import ltl_pkg::*;

    logic [TIME_W-1:0] start_times [MAX_LINES];
    logic [CNT_W-1:0]  lines_valid;
    logic [CNT_W-1:0]  hint_line;
    logic [TIME_W-1:0] shown_start;
    res_t              answers_due [$];

    function automatic void forget_position();
        hint_line   = HINT_NONE;
        shown_start = TIME_NONE;
    endfunction

    function automatic res_t lookup_line(input logic [TIME_W-1:0] pos, input logic frc);
        int                n;
        int                i;
        int                lo;
        int                hi;
        logic [TIME_W-1:0] stamp;
        res_t              r;
        r = RES_KEEP;
        n = (lines_valid > COUNT_MAX) ? MAX_LINES : int'(lines_valid);
        if (n == 0)
        begin
            if (frc)
                r = RES_BLANK;
            return r;
        end
        i = (int'(hint_line) < n) ? int'(hint_line) : 0;
        while (i > 0 && start_times[i] > pos)
            i--;
        while (i + 1 < n && start_times[i + 1] <= pos)
            i++;
        if (start_times[i] > pos)
        begin
            if (frc || shown_start != TIME_NONE)
            begin
                forget_position();
                r = RES_BLANK;
            end
            return r;
        end
        hint_line = CNT_W'(i);
        stamp = start_times[i];
        if (!frc && stamp == shown_start)
            return r;
        shown_start = stamp;
        lo = i;
        while (lo > 0 && start_times[lo - 1] == stamp)
            lo--;
        hi = i;
        while (hi + 1 < n && start_times[hi + 1] == stamp)
            hi++;
        r.action     = ACT_SHOW;
        r.first_line = IDX_W'(lo);
        r.last_line  = IDX_W'(hi);
        r.line_time  = stamp;
        return r;
    endfunction

    task automatic report_field(input string field, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            lines_valid = '0;
            forget_position();
            answers_due.delete();
            mismatches = 0;
            answers_outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                lines_valid = cfg_data;
            if (out_valid && !out_stall)
            begin
                got = '{action, first_line, last_line, line_time};
                if (answers_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result transfer with nothing expected, action %0d",
                             $time, got.action);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got.action !== want.action)
                        report_field("action", want.action, got.action);
                    if (got.first_line !== want.first_line)
                        report_field("first_line", want.first_line, got.first_line);
                    if (got.last_line !== want.last_line)
                        report_field("last_line", want.last_line, got.last_line);
                    if (got.line_time !== want.line_time)
                        report_field("line_time", want.line_time, got.line_time);
                end
            end
            if (in_valid && !in_stall)
            begin
                want = RES_KEEP;
                case (op)
                    OP_LOAD:
                    begin
                        start_times[entry_index] = entry_time;
                        forget_position();
                    end
                    OP_QUERY:
                        want = lookup_line(query_time, force_req);
                    OP_SEEK:
                        forget_position();
                    default:
                        want = RES_KEEP;
                endcase
                answers_due.push_back(want);
            end
            answers_outstanding <= answers_due.size();
        end
    end

endmodule

// ===== test/lyric_timeline_line_lookup_test.sv =====
// ---------------------------------------------------------------------------
// Line lookup testbench
// Drives the line lookup block with a short directed sequence and then with
// phases of random traffic, each phase setting a new line count, at times
// loading a mostly sorted time table and following a playback position with
// queries, seeks and loads. Both channels idle at random in most phases; a
// checker beside the block predicts and compares every result transfer.
// ---------------------------------------------------------------------------
module lyric_timeline_line_lookup_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ltl_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1450;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CNT_W-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      op          = OP_SEEK;
    logic [IDX_W-1:0]     entry_index = '0;
    logic [TIME_W-1:0]    entry_time  = '0;
    logic [TIME_W-1:0]    query_time  = '0;
    logic                 force_req   = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [ACT_W-1:0]     action;
    logic [IDX_W-1:0]     first_line;
    logic [IDX_W-1:0]     last_line;
    logic [TIME_W-1:0]    line_time;
    logic                 gaps_on     = 1'b1;
    int                   answers_outstanding;
    int                   mismatches;
    int                   items_sent  = 0;
    logic [TIME_W-1:0]    line_starts [MAX_LINES];

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    lyric_timeline_line_lookup u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .entry_index (entry_index),
        .entry_time  (entry_time),
        .query_time  (query_time),
        .force_req   (force_req),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .action      (action),
        .first_line  (first_line),
        .last_line   (last_line),
        .line_time   (line_time)
    );

    lyric_timeline_line_lookup_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .op                  (op),
        .entry_index         (entry_index),
        .entry_time          (entry_time),
        .query_time          (query_time),
        .force_req           (force_req),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .action              (action),
        .first_line          (first_line),
        .last_line           (last_line),
        .line_time           (line_time),
        .answers_outstanding (answers_outstanding),
        .mismatches          (mismatches)
    );

    always @(posedge clk)
        out_stall <= gaps_on && ($urandom_range(0, 99) < 36);

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_NONE : s[TIME_W-1:0];
    endfunction

    task automatic send_transfer(input logic [OP_W-1:0] code, input logic [IDX_W-1:0] slot,
                                 input logic [TIME_W-1:0] etime,
                                 input logic [TIME_W-1:0] qtime, input logic frc);
        while (gaps_on && $urandom_range(0, 99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= code;
        entry_index <= slot;
        entry_time  <= etime;
        query_time  <= qtime;
        force_req   <= frc;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic load_line(input logic [IDX_W-1:0] slot, input logic [TIME_W-1:0] stamp);
        line_starts[slot] = stamp;
        items_sent++;
        send_transfer(OP_LOAD, slot, stamp, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic query_at(input logic [TIME_W-1:0] pos, input logic frc);
        items_sent++;
        send_transfer(OP_QUERY, IDX_W'($urandom_range(0, 255)), $urandom, pos, frc);
    endtask

    task automatic seek_to();
        items_sent++;
        send_transfer(OP_SEEK, IDX_W'($urandom_range(0, 255)), $urandom, $urandom,
                      1'($urandom_range(0, 1)));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (answers_outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_line_count(input logic [CNT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        #60_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int                phase;
        int                n_req;
        int                n_eff;
        int                filled;
        int                mixed;
        int                hold_at;
        int                sel;
        int                pick;
        int                slot;
        logic              unsorted;
        logic [TIME_W-1:0] play_pos;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] base;
        foreach (line_starts[k])
            line_starts[k] = '0;
        filled = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        query_at(32'd0, 1'b0);
        query_at(TIME_NONE, 1'b1);
        items_sent++;
        send_transfer(OP_UNUSED, 8'd0, '0, '0, 1'b0);
        seek_to();
        drain_results();
        write_line_count(9'd4);
        load_line(8'd0, 32'd1000);
        load_line(8'd1, 32'd1000);
        load_line(8'd2, 32'd2000);
        load_line(8'd3, TIME_NONE);
        load_line(8'd255, TIME_NONE);
        query_at(32'd500, 1'b0);
        query_at(32'd500, 1'b1);
        query_at(32'd1000, 1'b0);
        query_at(32'd1500, 1'b0);
        query_at(32'd1500, 1'b1);
        query_at(32'd2000, 1'b0);
        query_at(32'd500, 1'b0);
        query_at(TIME_NONE, 1'b0);
        query_at(TIME_NONE, 1'b0);
        query_at(32'd0, 1'b0);
        query_at(32'd2500, 1'b0);
        query_at(TIME_NONE, 1'b0);
        drain_results();
        write_line_count(9'd2);
        query_at(32'd1200, 1'b0);
        seek_to();
        query_at(32'd1200, 1'b0);
        filled = 4;

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase == 0)
                n_req = 0;
            else if (phase == 1)
                n_req = MAX_LINES;
            else if (phase == 2)
                n_req = 511;
            else if (phase % 6 == 5)
                n_req = $urandom_range(MAX_LINES + 1, 510);
            else if ($urandom_range(0, 3) == 0)
                n_req = $urandom_range(17, 64);
            else
                n_req = $urandom_range(1, 16);
            n_eff = (n_req > MAX_LINES) ? MAX_LINES : n_req;
            gaps_on <= !(phase == 3 || phase == 4);
            drain_results();
            write_line_count(CNT_W'(n_req));

            if (n_eff > filled || (n_eff <= 64 && $urandom_range(0, 3) != 0))
            begin
                unsorted = ($urandom_range(0, 7) == 0);
                case ($urandom_range(0, 3))
                    0: stamp = '0;
                    1: stamp = $urandom_range(0, 1000);
                    2: stamp = $urandom;
                    default: stamp = TIME_NONE - $urandom_range(0, 20000);
                endcase
                for (int k = 0; k < n_eff; k++)
                begin
                    if (unsorted)
                        stamp = $urandom;
                    else if (k > 0)
                    begin
                        pick = $urandom_range(0, 19);
                        if (pick == 19)
                            stamp = sat_add(stamp, $urandom);
                        else if (pick >= 5)
                            stamp = sat_add(stamp, $urandom_range(1, 4000));
                    end
                    load_line(IDX_W'(k), stamp);
                end
                if (n_eff > filled)
                    filled = n_eff;
            end

            play_pos = (n_eff > 0) ? line_starts[0] : $urandom;
            play_pos = (play_pos > 3000) ? play_pos - $urandom_range(0, 3000) : '0;
            mixed = $urandom_range(40, 80);
            hold_at = $urandom_range(0, mixed - 1);
            for (int m = 0; m < mixed; m++)
            begin
                if (m == hold_at)
                    drain_results();
                sel = $urandom_range(0, 99);
                if (sel < 74)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        play_pos = sat_add(play_pos, $urandom_range(0, 2500));
                    else if (pick < 88 && n_eff > 0)
                    begin
                        base = line_starts[$urandom_range(0, n_eff - 1)];
                        case ($urandom_range(0, 2))
                            0: play_pos = (base == 0) ? '0 : base - 1;
                            1: play_pos = base;
                            default: play_pos = sat_add(base, 1);
                        endcase
                    end
                    else if (pick < 94)
                        play_pos = $urandom;
                    else
                        play_pos = ($urandom_range(0, 1) != 0) ? TIME_NONE : '0;
                    query_at(play_pos, $urandom_range(0, 99) < 15);
                end
                else if (sel < 84)
                begin
                    seek_to();
                    if (n_eff > 0)
                        play_pos = line_starts[$urandom_range(0, n_eff - 1)];
                end
                else if (sel < 96)
                begin
                    slot = $urandom_range(0, MAX_LINES - 1);
                    if (slot > 0 && $urandom_range(0, 1) != 0)
                        stamp = line_starts[slot - 1];
                    else
                        stamp = $urandom;
                    load_line(IDX_W'(slot), stamp);
                end
                else
                begin
                    items_sent++;
                    send_transfer(OP_UNUSED, IDX_W'($urandom_range(0, 255)), $urandom,
                                  $urandom, 1'($urandom_range(0, 1)));
                end
            end
            phase++;
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
